### rtl/mgs_pkg.sv
package mgs_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int COUNT_WIDTH = 48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL_SP,
        ST_MUL_PP,
        ST_MUL_PB,
        ST_OUTPUT
    } t_state;

endpackage

### rtl/mgs_if.sv
interface mgs_in_if #(
    parameter int DATA_WIDTH  = mgs_pkg::DATA_WIDTH,
    parameter int COUNT_WIDTH = mgs_pkg::COUNT_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [DATA_WIDTH-1:0]  base;
    logic [COUNT_WIDTH-1:0] term_count;
    logic [DATA_WIDTH-1:0]  modulus;

    modport source (output valid, output base, output term_count, output modulus, input ready);
    modport sink   (input valid, input base, input term_count, input modulus, output ready);
endinterface

interface mgs_out_if #(
    parameter int DATA_WIDTH = mgs_pkg::DATA_WIDTH
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] sum_mod;

    modport source (output valid, output sum_mod, input ready);
    modport sink   (input valid, input sum_mod, output ready);
endinterface

### rtl/mgs_mulmod.sv
module mgs_mulmod #(
    parameter int DATA_WIDTH = mgs_pkg::DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_x,
    input  logic [DATA_WIDTH-1:0] i_y,
    input  logic [DATA_WIDTH-1:0] i_mod,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_result
);

    localparam int CntW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CntW-1:0]       r_cnt, n_cnt;
    logic [DATA_WIDTH-1:0] r_acc, n_acc;
    logic [DATA_WIDTH-1:0] r_x, n_x;
    logic [DATA_WIDTH-1:0] r_y, n_y;

    logic [DATA_WIDTH:0]   w_mod_ext;
    logic [DATA_WIDTH:0]   w_dbl;
    logic [DATA_WIDTH:0]   w_dbl_red;
    logic [DATA_WIDTH:0]   w_add;
    logic [DATA_WIDTH:0]   w_add_red;

    // One step of the shift-and-add product: acc = (2 * acc + bit * x) mod m.
    always_comb begin
        w_mod_ext = {1'b0, i_mod};
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= w_mod_ext) ? (w_dbl - w_mod_ext) : w_dbl;
        w_add     = {1'b0, w_dbl_red[DATA_WIDTH-1:0]}
                  + (r_y[DATA_WIDTH-1] ? {1'b0, r_x} : '0);
        w_add_red = (w_add >= w_mod_ext) ? (w_add - w_mod_ext) : w_add;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CntW'(DATA_WIDTH - 1);
            n_acc  = '0;
            n_x    = i_x;
            n_y    = i_y;
        end else if (r_busy) begin
            n_acc = w_add_red[DATA_WIDTH-1:0];
            n_y   = {r_y[DATA_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

### rtl/modular_geometric_sum_core.sv
// Each item runs as a chain of modular products on the shared modular multiplier: one reduction
// of the base, then per bit of term_count a sum and a square step, plus a base step per one bit;
// the multiplier resolves one multiplier bit per cycle.
// Throughput: one item at a time; the input is not ready until the result transfer completes.
// A zero modulus offers its result in the cycle after the input transfer.
// Reset is synchronous and active low; it returns the sequencer to idle with no result pending.
module modular_geometric_sum_core #(
    parameter int DATA_WIDTH  = mgs_pkg::DATA_WIDTH,
    parameter int COUNT_WIDTH = mgs_pkg::COUNT_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mgs_in_if.sink    i_in,
    mgs_out_if.source o_out
);

    localparam int IdxW = (COUNT_WIDTH > 1) ? $clog2(COUNT_WIDTH) : 1;

    mgs_pkg::t_state r_state, n_state;

    logic [DATA_WIDTH-1:0]  r_base, n_base;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [DATA_WIDTH-1:0]  r_mod, n_mod;
    logic [DATA_WIDTH-1:0]  r_sum, n_sum;
    logic [DATA_WIDTH-1:0]  r_pw, n_pw;
    logic [IdxW-1:0]        r_idx, n_idx;

    logic                   w_mul_start;
    logic [DATA_WIDTH-1:0]  w_mul_x;
    logic [DATA_WIDTH-1:0]  w_mul_y;
    logic                   w_mul_done;
    logic [DATA_WIDTH-1:0]  w_mul_res;
    logic [DATA_WIDTH-1:0]  w_one_mod;
    logic [DATA_WIDTH:0]    w_add;
    logic [DATA_WIDTH-1:0]  w_sum_plus;
    logic                   w_bit;

    mgs_mulmod #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_x      (w_mul_x),
        .i_y      (w_mul_y),
        .i_mod    (r_mod),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    always_comb begin
        w_add      = {1'b0, r_sum} + {1'b0, w_mul_res};
        w_sum_plus = (w_add >= {1'b0, r_mod}) ? w_add[DATA_WIDTH-1:0] - r_mod
                                              : w_add[DATA_WIDTH-1:0];
        w_bit      = r_count[r_idx];
        w_one_mod  = (i_in.modulus == DATA_WIDTH'(1)) ? '0 : DATA_WIDTH'(1);
    end

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_count     = r_count;
        n_mod       = r_mod;
        n_sum       = r_sum;
        n_pw        = r_pw;
        n_idx       = r_idx;
        w_mul_start = 1'b0;
        w_mul_x     = r_sum;
        w_mul_y     = r_pw;
        case (r_state)
            mgs_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_base  = i_in.base;
                    n_count = i_in.term_count;
                    n_mod   = i_in.modulus;
                    n_sum   = '0;
                    n_pw    = w_one_mod;
                    n_idx   = IdxW'(COUNT_WIDTH - 1);
                    if (i_in.modulus == '0) begin
                        n_state = mgs_pkg::ST_OUTPUT;
                    end else begin
                        // Horner reduction of the base: (1 * base) mod m.
                        w_mul_start = 1'b1;
                        w_mul_x     = w_one_mod;
                        w_mul_y     = i_in.base;
                        n_state     = mgs_pkg::ST_REDUCE;
                    end
                end
            end
            mgs_pkg::ST_REDUCE: begin
                if (w_mul_done) begin
                    n_base      = w_mul_res;
                    w_mul_start = 1'b1;
                    w_mul_x     = r_sum;
                    w_mul_y     = r_pw;
                    n_state     = mgs_pkg::ST_MUL_SP;
                end
            end
            mgs_pkg::ST_MUL_SP: begin
                if (w_mul_done) begin
                    n_sum       = w_sum_plus;
                    w_mul_start = 1'b1;
                    w_mul_x     = r_pw;
                    w_mul_y     = r_pw;
                    n_state     = mgs_pkg::ST_MUL_PP;
                end
            end
            mgs_pkg::ST_MUL_PP: begin
                if (w_mul_done) begin
                    n_pw = w_mul_res;
                    if (w_bit) begin
                        n_sum       = w_sum_plus;
                        w_mul_start = 1'b1;
                        w_mul_x     = w_mul_res;
                        w_mul_y     = r_base;
                        n_state     = mgs_pkg::ST_MUL_PB;
                    end else if (r_idx == '0) begin
                        n_state = mgs_pkg::ST_OUTPUT;
                    end else begin
                        n_idx       = r_idx - 1'b1;
                        w_mul_start = 1'b1;
                        w_mul_x     = r_sum;
                        w_mul_y     = w_mul_res;
                        n_state     = mgs_pkg::ST_MUL_SP;
                    end
                end
            end
            mgs_pkg::ST_MUL_PB: begin
                if (w_mul_done) begin
                    n_pw = w_mul_res;
                    if (r_idx == '0) begin
                        n_state = mgs_pkg::ST_OUTPUT;
                    end else begin
                        n_idx       = r_idx - 1'b1;
                        w_mul_start = 1'b1;
                        w_mul_x     = r_sum;
                        w_mul_y     = w_mul_res;
                        n_state     = mgs_pkg::ST_MUL_SP;
                    end
                end
            end
            mgs_pkg::ST_OUTPUT: begin
                if (o_out.ready) begin
                    n_state = mgs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mgs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_count <= n_count;
        r_mod   <= n_mod;
        r_sum   <= n_sum;
        r_pw    <= n_pw;
        r_idx   <= n_idx;
    end

    assign i_in.ready    = (r_state == mgs_pkg::ST_IDLE);
    assign o_out.valid   = (r_state == mgs_pkg::ST_OUTPUT);
    assign o_out.sum_mod = r_sum;

endmodule

### rtl/mgs_checker.sv
module mgs_checker #(
    parameter int DATA_WIDTH = mgs_pkg::DATA_WIDTH
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [DATA_WIDTH-1:0] i_sum_mod
);

    // A result waiting for its transfer stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before its transfer");

    // A result waiting for its transfer keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_sum_mod))
        else $error("result changed before its transfer");

    // The block takes no new item right after an input transfer.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an input transfer");

    // Only one item is in the block at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

endmodule

bind modular_geometric_sum_core mgs_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_mgs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sum_mod   (o_out.sum_mod)
);

### tb/modular_geometric_sum_core_test.sv
`timescale 1ns / 100ps

module modular_geometric_sum_core_test;

    localparam int DATA_WIDTH      = mgs_pkg::DATA_WIDTH;
    localparam int COUNT_WIDTH     = mgs_pkg::COUNT_WIDTH;
    localparam int CLK_PERIOD      = 10;
    localparam int RANDOM_JOBS     = 120;
    localparam int QUIET_TAIL      = 20;
    localparam int LONG_HOLD_AFTER = 30;
    localparam int LONG_HOLD_LEN   = 12000;
    localparam int SETTLE_CYCLES   = 5000;

    typedef struct {
        logic [DATA_WIDTH-1:0]  base;
        logic [COUNT_WIDTH-1:0] term_count;
        logic [DATA_WIDTH-1:0]  modulus;
        bit                     drain_first;
    } t_series_job;

    logic clk;
    logic rst_n;

    mgs_in_if  in_ch ();
    mgs_out_if out_ch ();

    modular_geometric_sum_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_series_job           pending_jobs[$];
    logic [DATA_WIDTH-1:0] expected_sums[$];
    int                    n_total;
    int                    n_sent = 0;
    int                    n_checked = 0;
    int                    n_fail = 0;
    int                    gap_left = 0;
    int                    stall_left = 0;
    int                    hold_left = 0;
    bit                    long_hold_done = 1'b0;

    function automatic logic [DATA_WIDTH-1:0] geo_sum_mod(
        input logic [DATA_WIDTH-1:0]  ratio,
        input logic [COUNT_WIDTH-1:0] terms,
        input logic [DATA_WIDTH-1:0]  modulus
    );
        longint unsigned m;
        longint unsigned r;
        longint unsigned partial;
        longint unsigned power;
        m = longint'(modulus);
        if (m == 0) begin
            return '0;
        end
        r       = longint'(ratio) % m;
        power   = 1 % m;
        partial = 0;
        for (int i = COUNT_WIDTH - 1; i >= 0; i--) begin
            partial = (partial + (partial * power) % m) % m;
            power   = (power * power) % m;
            if (terms[i]) begin
                partial = (partial + power) % m;
                power   = (power * r) % m;
            end
        end
        return partial[DATA_WIDTH-1:0];
    endfunction

    function automatic t_series_job make_job(
        input logic [DATA_WIDTH-1:0]  ratio,
        input logic [COUNT_WIDTH-1:0] terms,
        input logic [DATA_WIDTH-1:0]  modulus,
        input bit                     drain
    );
        t_series_job job;
        job.base        = ratio;
        job.term_count  = terms;
        job.modulus     = modulus;
        job.drain_first = drain;
        return job;
    endfunction

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk) begin : drive_proc
        logic next_valid;
        if (!rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.base       <= '0;
            in_ch.term_count <= '0;
            in_ch.modulus    <= '0;
            gap_left = 0;
        end else begin
            next_valid = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                expected_sums.push_back(geo_sum_mod(in_ch.base, in_ch.term_count,
                                                    in_ch.modulus));
                n_sent = n_sent + 1;
                if (n_sent < n_total - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
                    gap_left = $urandom_range(1, 12);
                end
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (gap_left > 0) begin
                    gap_left   = gap_left - 1;
                    next_valid = 1'b0;
                end else if (pending_jobs.size() == 0) begin
                    next_valid = 1'b0;
                end else if (pending_jobs[0].drain_first && expected_sums.size() != 0) begin
                    next_valid = 1'b0;
                end else begin
                    t_series_job job;
                    job = pending_jobs.pop_front();
                    in_ch.base       <= job.base;
                    in_ch.term_count <= job.term_count;
                    in_ch.modulus    <= job.modulus;
                    next_valid = 1'b1;
                end
            end
            in_ch.valid <= next_valid;
        end
    end

    always @(posedge clk) begin : collect_proc
        logic                  next_ready;
        logic [DATA_WIDTH-1:0] want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_sums.size() == 0) begin
                    $error("sum_mod: no transfer expected, actual %0d", out_ch.sum_mod);
                    n_fail = n_fail + 1;
                end else begin
                    want = expected_sums.pop_front();
                    if (out_ch.sum_mod !== want) begin
                        $error("sum_mod mismatch: expected %0d, actual %0d",
                               want, out_ch.sum_mod);
                        n_fail = n_fail + 1;
                    end
                    n_checked = n_checked + 1;
                end
            end
            next_ready = 1'b1;
            if (hold_left > 0) begin
                hold_left  = hold_left - 1;
                next_ready = 1'b0;
            end else if (!long_hold_done && n_sent >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_LEN - 1;
                next_ready     = 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                next_ready = 1'b0;
            end else if (n_sent < n_total - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 11);
                next_ready = 1'b0;
            end
            out_ch.ready <= next_ready;
        end
    end

    initial begin
        logic [DATA_WIDTH-1:0]  r;
        logic [COUNT_WIDTH-1:0] k;
        logic [DATA_WIDTH-1:0]  m;

        rst_n = 1'b0;

        pending_jobs.push_back(make_job(32'd2, 48'd10, 32'd1000, 1'b0));
        pending_jobs.push_back(make_job(32'd5, 48'd0, 32'd7, 1'b0));
        pending_jobs.push_back(make_job('1, '1, 32'd1, 1'b0));
        pending_jobs.push_back(make_job(32'd9, 48'd77, 32'd0, 1'b0));
        pending_jobs.push_back(make_job(32'd3, 48'd4, 32'd0, 1'b0));
        pending_jobs.push_back(make_job(32'd0, 48'd1, 32'd13, 1'b1));
        pending_jobs.push_back(make_job(32'd0, 48'd5, 32'd13, 1'b0));
        pending_jobs.push_back(make_job(32'd1, '1, '1, 1'b0));
        pending_jobs.push_back(make_job('1, '1, '1, 1'b0));
        pending_jobs.push_back(make_job('1, '1, 32'hFFFF_FFFB, 1'b0));
        pending_jobs.push_back(make_job(32'd1000, 48'd100, 32'd7, 1'b0));
        pending_jobs.push_back(make_job(32'd5, 48'd1, 32'd3, 1'b0));
        pending_jobs.push_back(make_job(32'd1, 48'd3, 32'd2, 1'b0));
        pending_jobs.push_back(make_job(32'h8000_0000, 48'h8000_0000_0000,
                                        32'h8000_0001, 1'b0));
        pending_jobs.push_back(make_job(32'hFFFF_FFFE, 48'd2, '1, 1'b0));
        pending_jobs.push_back(make_job(32'hAAAA_AAAA, 48'h5555_5555_5555,
                                        32'h5555_5555, 1'b0));
        pending_jobs.push_back(make_job(32'h5555_5555, 48'hAAAA_AAAA_AAAA,
                                        32'hAAAA_AAAA, 1'b0));
        pending_jobs.push_back(make_job(32'd2, 48'd1, '1, 1'b0));
        pending_jobs.push_back(make_job(32'd7, '1, 32'd2, 1'b0));

        for (int i = 0; i < RANDOM_JOBS; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                r = $urandom();
                k = {16'($urandom()), 32'($urandom())};
                k = k >> $urandom_range(0, COUNT_WIDTH - 1);
                m = $urandom();
                if ($urandom_range(0, 3) == 0) begin
                    m = m >> $urandom_range(0, DATA_WIDTH - 2);
                end
            end else begin
                m = $urandom_range(0, 16);
                r = ($urandom_range(0, 1) == 0) ? m - DATA_WIDTH'(1) : $urandom_range(0, 40);
                k = COUNT_WIDTH'($urandom_range(0, 20));
            end
            pending_jobs.push_back(make_job(r, k, m, i == RANDOM_JOBS / 2));
        end
        n_total = pending_jobs.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_total || expected_sums.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Checked %0d sums over %0d series: empty and single-term counts,", n_checked,
                 n_sent);
        $display("unit and zero moduli, oversized bases, a drained pause and a long output hold.");
        if (n_fail == 0 && expected_sums.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/mgs_pkg.sv
rtl/mgs_if.sv
rtl/mgs_mulmod.sv
rtl/modular_geometric_sum_core.sv
rtl/mgs_checker.sv
tb/modular_geometric_sum_core_test.sv
